// ===== hw/rtl/radix_converter_core_defines.svh =====
// ----------------------------------------------------------------------------
// radix_converter_core assertion macros
// Shared property wrappers; clk and rst_n are taken from the calling module.
// ----------------------------------------------------------------------------
`ifndef RADIX_CONVERTER_CORE_DEFINES_SVH
`define RADIX_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication
`define RCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg
// Types, constants and digit helpers for the radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int DIGIT_SLOTS = 32;
  localparam int SLOT_W     = 5;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_RADIX = 1'd1;

  localparam logic [RADIX_W-1:0] SRC_RADIX_RST = 5'd10;
  localparam logic [RADIX_W-1:0] TGT_RADIX_RST = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;

  localparam logic [SLOT_W-1:0]  SLOT_LAST     = 5'd31;

  // input character ranges
  localparam logic [7:0] ASC_0  = 8'h30;
  localparam logic [7:0] ASC_9  = 8'h39;
  localparam logic [7:0] ASC_LA = 8'h61;
  localparam logic [7:0] ASC_LF = 8'h66;
  localparam logic [7:0] ASC_UA = 8'h41;
  localparam logic [7:0] ASC_UF = 8'h46;

  // output character bases
  localparam logic [6:0] OUT_ZERO = 7'h30;
  localparam logic [6:0] OUT_LA   = 7'h61;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last_digit;
  } out_t;

  typedef struct packed {
    logic start;
    logic from_quot;  // divide the held quotient instead of the dividend port
  } div_ctl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               quot_zero;
    logic [DIGIT_W-1:0] rem;
  } div_sts_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= ASC_0 && c <= ASC_9) d = c - ASC_0;
    else if (c >= ASC_LA && c <= ASC_LF) d = c - ASC_LA + 8'd10;
    else if (c >= ASC_UA && c <= ASC_UF) d = c - ASC_UA + 8'd10;
    return d[DIGIT_W-1:0];
  endfunction

  function automatic logic [6:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d < DEC_LIMIT) c = OUT_ZERO + {3'b000, d};
    else c = OUT_LA + {3'b000, d - DEC_LIMIT};
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rcc_ram.sv =====
// ----------------------------------------------------------------------------
// rcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rcc_divider.sv =====
// ----------------------------------------------------------------------------
// rcc_divider
// Iterative divider by a small radix: four restoring steps per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_divider #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rcc_pkg::div_ctl_t       ctl,
  input  wire logic [VALUE_BITS-1:0]   dividend,
  input  wire logic [rcc_pkg::RADIX_W-1:0] divisor,
  output rcc_pkg::div_sts_t            sts
);
  import rcc_pkg::*;

  localparam int QW    = ((VALUE_BITS + 3) / 4) * 4;
  localparam int STEPS = QW / 4;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic [QW-1:0]      q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;

  // four long-division steps on the top nibble of the quotient register
  always_comb begin
    logic [RADIX_W-1:0] part;
    logic [3:0]         qbits;
    logic [DIGIT_W-1:0] r;
    r = rem_r;
    qbits = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      part = {r, q_r[QW-4+i]};
      if (part >= divisor) begin
        part = part - divisor;
        qbits[i] = 1'b1;
      end
      r = part[DIGIT_W-1:0];
    end
    rem_nxt = r;
    q_nxt   = {q_r[QW-5:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      if (!ctl.from_quot) begin
        q_r <= QW'(dividend);
      end
      rem_r <= '0;
      cnt_r <= CNT_LAST;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_comb begin
    sts.busy      = busy_r;
    sts.done      = done_r;
    sts.quot_zero = (q_r == '0);
    sts.rem       = rem_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/radix_converter_core.sv =====
// ----------------------------------------------------------------------------
// radix_converter_core
// Streams digit characters in, converts the number and streams digits out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one ASCII digit character per request, most significant first;
//           last_char closes the number. Non-digit characters count as 0.
//   out_* : lowercase ASCII digits in the target radix, most significant
//           first; last_digit flags the least significant one.
//   cfg_* : write-only radix registers (index 0 source, 1 target), 2..16,
//           clamped on use. Write only while idle.
// Flow (Q = ceil(VALUE_BITS/4), 8 for the default width):
//   A plain character is folded into the accumulator; in_ready stays
//   high, so plain characters go back to back. A closing character
//   runs the shared divider for Q steps per output digit, then each
//   digit goes through the registered digit store read (ST_OUT_RD,
//   then ST_OUT_LD); the input is held until the final digit is loaded.
// Reset: radixes go to 10 and 2, accumulator and digit count clear, no
//   request is pending on either channel.
// Stall: a result waits in the output register; the digit readout and the
//   input pause until out_ready. Once the final digit is loaded, the next
//   number's characters are taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_converter_core_defines.svh"

module radix_converter_core #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rcc_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rcc_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcc_pkg::RADIX_W-1:0]   cfg_wdata
);
  import rcc_pkg::*;

  localparam int PW = VALUE_BITS + RADIX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_OUT_RD = 2'd2;
  localparam logic [1:0] ST_OUT_LD = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [RADIX_W-1:0]    src_radix_r, tgt_radix_r;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt, acc_sum;
  logic [PW-1:0]         prod;
  logic [COUNT_W-1:0]    digit_cnt_r, digit_cnt_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;
  logic                  in_fire;

  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic                  ram_we;
  logic [DIGIT_W-1:0]    ram_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign prod    = PW'(acc_r) * PW'(clamp_radix(src_radix_r));
  assign acc_sum = prod[VALUE_BITS-1:0] + VALUE_BITS'(char_to_digit(in_data.char_code));

  // radix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_radix_r <= SRC_RADIX_RST;
      tgt_radix_r <= TGT_RADIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_RADIX: src_radix_r <= cfg_wdata;
        REG_TGT_RADIX: tgt_radix_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rcc_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (acc_sum),
    .divisor  (clamp_radix(tgt_radix_r)),
    .sts      (div_sts)
  );

  rcc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(DIGIT_SLOTS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_cnt_r[SLOT_W-1:0]),
    .wdata (div_sts.rem),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    digit_cnt_nxt = digit_cnt_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_ctl       = '0;
    ram_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.last_char) begin
            acc_nxt           = '0;
            digit_cnt_nxt     = '0;
            div_ctl.start     = 1'b1;
            state_nxt         = ST_DIV;
          end else begin
            acc_nxt = acc_sum;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          ram_we        = 1'b1;
          digit_cnt_nxt = digit_cnt_r + 1'b1;
          // stop once the quotient is spent or the store is full
          if (div_sts.quot_zero || digit_cnt_r[SLOT_W-1:0] == SLOT_LAST) begin
            slot_nxt  = digit_cnt_r[SLOT_W-1:0];
            state_nxt = ST_OUT_RD;
          end else begin
            div_ctl.start     = 1'b1;
            div_ctl.from_quot = 1'b1;
          end
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.digit_char = digit_to_char(ram_rdata);
          out_data_nxt.last_digit = (slot_r == '0);
          if (slot_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt  = slot_r - 1'b1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      digit_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  `RCC_ASSERT_NOW(a_no_input_while_dividing, div_sts.busy, !in_ready, "input taken during divide")
  `RCC_ASSERT_NEXT(a_last_starts_divide, in_fire && in_data.last_char, div_sts.busy, "closing request did not start divider")
  `RCC_ASSERT_NEXT(a_divide_continues, state_r == ST_DIV && div_sts.done && !div_sts.quot_zero && digit_cnt_r[SLOT_W-1:0] != SLOT_LAST, div_sts.busy, "digit loop stopped early")
  `RCC_ASSERT_NOW(a_done_not_busy, div_sts.done, !div_sts.busy, "divider done while busy")

endmodule

`default_nettype wire

// ===== bench/radix_converter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_converter_core_tb
// Streams digit-character numbers into the converter under several radix
// settings, predicts the emitted digits and checks them in order, with
// random idle gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module radix_converter_core_tb;
  import rcc_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 60;
  localparam int NUM_PHASES    = 6;

  class digit_scoreboard;
    logic [RADIX_W-1:0] src_reg;
    logic [RADIX_W-1:0] tgt_reg;
    logic [31:0]        acc;
    out_t               pending_digits[$];
    int                 errors;

    function new();
      src_reg = SRC_RADIX_RST;
      tgt_reg = TGT_RADIX_RST;
      acc     = '0;
      errors  = 0;
    endfunction

    function logic [RADIX_W-1:0] eff_radix(logic [RADIX_W-1:0] r);
      if (r < RADIX_MIN) return RADIX_MIN;
      if (r > RADIX_MAX) return RADIX_MAX;
      return r;
    endfunction

    function logic [RADIX_W-1:0] source_radix();
      return eff_radix(src_reg);
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= ASC_0 && c <= ASC_9) t = c - ASC_0;
      else if (c >= ASC_LA && c <= ASC_LF) t = c - ASC_LA + 8'd10;
      else if (c >= ASC_UA && c <= ASC_UF) t = c - ASC_UA + 8'd10;
      return t[3:0];
    endfunction

    function logic [6:0] ascii_digit(logic [3:0] d);
      if (d < 4'd10) return OUT_ZERO + {3'b000, d};
      return OUT_LA + {3'b000, d - 4'd10};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIX_W-1:0] v);
      if (idx == REG_SRC_RADIX) src_reg = v;
      else if (idx == REG_TGT_RADIX) tgt_reg = v;
    endfunction

    // fold one character in; a closing character queues the converted digits
    function void note_char(in_t item);
      logic [31:0] v;
      logic [31:0] divisor;
      logic [31:0] rem;
      logic [3:0]  digs [32];
      int          n;
      out_t        o;
      acc = acc * {27'd0, eff_radix(src_reg)} + {28'd0, digit_value(item.char_code)};
      if (!item.last_char) return;
      v       = acc;
      divisor = {27'd0, eff_radix(tgt_reg)};
      n       = 0;
      // zero still yields one digit; no leading zeros otherwise
      while (n == 0 || (v != 0 && n < DIGIT_SLOTS)) begin
        rem     = v % divisor;
        digs[n] = rem[3:0];
        v       = v / divisor;
        n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
        o.digit_char = ascii_digit(digs[k]);
        o.last_digit = (k == 0);
        pending_digits.push_back(o);
      end
      acc = '0;
    endfunction

    function void check_digit(out_t got);
      out_t want;
      if (pending_digits.size() == 0) begin
        $error("unexpected result: digit_char %0h last_digit %0b",
               got.digit_char, got.last_digit);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      if (got.digit_char !== want.digit_char) begin
        $error("digit_char: expected %0h, actual %0h", want.digit_char, got.digit_char);
        errors++;
      end
      if (got.last_digit !== want.last_digit) begin
        $error("last_digit: expected %0b, actual %0b", want.last_digit, got.last_digit);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RADIX_W-1:0]   cfg_wdata = '0;

  digit_scoreboard sb;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;
  int cycle_count = 0;
  int chars_sent  = 0;

  radix_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] digit_text(int d, bit upper);
    logic [7:0] b;
    b = 8'(d);
    if (b < 8'd10) return ASC_0 + b;
    if (upper) return ASC_UA + b - 8'd10;
    return ASC_LA + b - 8'd10;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready  = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && out_ready) sb.check_digit(out_data);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic send_request(input in_t item, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(item);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    in_t item;
    for (int i = 0; i < s.len(); i++) begin
      item.char_code = s[i];
      item.last_char = (i == s.len() - 1);
      send_request(item, pick_gap());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sender pauses until every digit is out and the block has settled
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_digits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly well-formed numbers; some noise with stray bytes and early closes
  task automatic send_random_number();
    in_t                item;
    int                 len;
    int                 d;
    bit                 noisy;
    logic [RADIX_W-1:0] src;
    src   = sb.source_radix();
    noisy = ($urandom_range(99) < 15);
    if (noisy) len = $urandom_range(1, 6);
    else if ($urandom_range(9) == 0) len = $urandom_range(12, 34);
    else len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        item.char_code = 8'($urandom_range(255));
        item.last_char = (i == len - 1) || ($urandom_range(7) == 0);
      end else begin
        d = $urandom_range(src - 1);
        item.char_code = digit_text(d, 1'($urandom_range(1)));
        item.last_char = (i == len - 1);
      end
      send_request(item, pick_gap());
    end
  endtask

  initial begin
    logic [RADIX_W-1:0] src;
    logic [RADIX_W-1:0] tgt;
    int                 goal;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset radixes: decimal in, binary out; zero and the full 32-bit value
    send_text("0");
    send_text("4294967295");
    drain();
    // clamped to hex in, hex out; mixed case, a non-digit, wraparound to zero
    write_reg(REG_SRC_RADIX, 5'd31);
    write_reg(REG_TGT_RADIX, 5'd16);
    send_text("Ff");
    send_text("z");
    send_text("100000000");
    drain();
    // clamped to binary in: a digit above the radix counts at face value
    write_reg(REG_SRC_RADIX, 5'd1);
    write_reg(REG_TGT_RADIX, 5'd17);
    send_text("9");
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          src = RADIX_MIN;
          tgt = RADIX_MAX;
        end
        1: begin
          src = RADIX_MAX;
          tgt = RADIX_MIN;
        end
        2: begin
          src = 5'd0;
          tgt = 5'd31;
        end
        3: begin
          src = 5'd31;
          tgt = 5'd1;
        end
        default: begin
          src = RADIX_W'($urandom_range(31));
          tgt = RADIX_W'($urandom_range(31));
        end
      endcase
      write_reg(REG_SRC_RADIX, src);
      write_reg(REG_TGT_RADIX, tgt);
      quiet = (p == 1);
      if (p == 3) hold_req = 1'b1;
      goal = chars_sent + PHASE_ITEMS;
      while (chars_sent < goal) send_random_number();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_digits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
